@@ hw/rtl/frqsrt_pkg.sv @@
package frqsrt_pkg;

   localparam int VALUE_W   = 32;
   localparam int OPCODE_W  = 2;
   localparam int STATUS_W  = 3;
   localparam int REQ_DATA_W = 32;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_SPARE = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED        = 3'd0,
      ST_DROP_FULL    = 3'd1,
      ST_DROP_READING = 3'd2,
      ST_VALUE        = 3'd3,
      ST_EMPTY        = 3'd4,
      ST_CLEARED      = 3'd5
   } status_code_type;

   typedef enum logic [1:0] {
      RD_K,
      RD_JM1,
      RD_READ
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NEW,
      WR_INC,
      WR_KEY,
      WR_SHIFT
   } wr_sel_type;

   typedef enum logic [1:0] {
      K_HOLD,
      K_ZERO,
      K_ONE,
      K_INC
   } k_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SORT_K,
      S_SORT_KEY,
      S_SORT_J,
      S_SORT_CMP,
      S_READ_RD,
      S_READ_OUT,
      S_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic            latch;
      logic            clear;
      logic            set_res;
      status_code_type res_code;
      k_op_type        k_op;
      logic            j_load;
      logic            j_dec;
      logic            key_load;
      logic            rd_en;
      rd_sel_type      rd_sel;
      logic            wr_en;
      wr_sel_type      wr_sel;
      logic            items_inc;
      logic            distinct_inc;
      logic            start_read;
      logic            read_step;
      logic            load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       reading;
      logic       full;
      logic       items_zero;
      logic       k_end;
      logic       match;
      logic       j_zero;
      logic       key_first;
      logic       past_end;
      logic       rsp_free;
   } dp_status_type;

endpackage

@@ hw/rtl/frqsrt_ctrl.sv @@
module frqsrt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  frqsrt_pkg::dp_status_type sts,
   output frqsrt_pkg::dp_cmd_type    cmd
);
   import frqsrt_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.opcode == OP_CLEAR || sts.opcode == OP_SPARE) begin
               cmd.clear    = 1'b1;
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_CLEARED;
               state_in     = S_RESP;
            end else if (sts.opcode == OP_ADD) begin
               if (sts.reading) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = ST_DROP_READING;
                  state_in     = S_RESP;
               end else if (sts.full) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = ST_DROP_FULL;
                  state_in     = S_RESP;
               end else begin
                  cmd.k_op = K_ZERO;
                  state_in = S_SCAN_RD;
               end
            end else begin
               if (!sts.reading && !sts.items_zero) begin
                  cmd.k_op = K_ONE;
                  state_in = S_SORT_K;
               end else if (!sts.reading || sts.past_end) begin
                  cmd.set_res  = 1'b1;
                  cmd.res_code = ST_EMPTY;
                  state_in     = S_RESP;
               end else begin
                  state_in = S_READ_RD;
               end
            end
         end
         S_SCAN_RD: begin
            if (sts.k_end) begin
               cmd.wr_en        = 1'b1;
               cmd.wr_sel       = WR_NEW;
               cmd.distinct_inc = 1'b1;
               cmd.items_inc    = 1'b1;
               cmd.set_res      = 1'b1;
               cmd.res_code     = ST_ADDED;
               state_in         = S_RESP;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_K;
               state_in   = S_SCAN_CMP;
            end
         end
         S_SCAN_CMP: begin
            if (sts.match) begin
               cmd.wr_en     = 1'b1;
               cmd.wr_sel    = WR_INC;
               cmd.items_inc = 1'b1;
               cmd.set_res   = 1'b1;
               cmd.res_code  = ST_ADDED;
               state_in      = S_RESP;
            end else begin
               cmd.k_op = K_INC;
               state_in = S_SCAN_RD;
            end
         end
         S_SORT_K: begin
            if (sts.k_end) begin
               cmd.start_read = 1'b1;
               state_in       = S_READ_RD;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_K;
               state_in   = S_SORT_KEY;
            end
         end
         S_SORT_KEY: begin
            cmd.key_load = 1'b1;
            cmd.j_load   = 1'b1;
            state_in     = S_SORT_J;
         end
         S_SORT_J: begin
            if (sts.j_zero) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_KEY;
               cmd.k_op   = K_INC;
               state_in   = S_SORT_K;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_JM1;
               state_in   = S_SORT_CMP;
            end
         end
         S_SORT_CMP: begin
            cmd.wr_en = 1'b1;
            if (sts.key_first) begin
               cmd.wr_sel = WR_SHIFT;
               cmd.j_dec  = 1'b1;
               state_in   = S_SORT_J;
            end else begin
               cmd.wr_sel = WR_KEY;
               cmd.k_op   = K_INC;
               state_in   = S_SORT_K;
            end
         end
         S_READ_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_READ;
            state_in   = S_READ_OUT;
         end
         S_READ_OUT: begin
            cmd.read_step = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/frqsrt_dp.sv @@
module frqsrt_dp #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [frqsrt_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [frqsrt_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [frqsrt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [frqsrt_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                               rsp_tlast,
   input  frqsrt_pkg::dp_cmd_type             cmd,
   output frqsrt_pkg::dp_status_type          sts
);
   import frqsrt_pkg::*;

   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int AW = $clog2(MAX_ITEMS);
   localparam int EW = VALUE_W + CW + AW;

   logic [EW-1:0] mem [MAX_ITEMS];
   logic [EW-1:0] rd_ff, key_ff;

   opcode_type          op_ff;
   logic [VALUE_W-1:0]  val_ff;
   logic [CW-1:0]       items_ff, distinct_ff, read_entry_ff, repeat_ff, k_ff, j_ff;
   logic                reading_ff;
   status_code_type     res_status_ff, rsp_status_ff;
   logic [VALUE_W-1:0]  res_value_ff, rsp_value_ff;
   logic                res_last_ff, rsp_last_ff, rsp_valid_ff;

   logic [VALUE_W-1:0]  rd_val;
   logic [CW-1:0]       rd_cnt, key_cnt, eff_cnt, rem_cnt, read_entry_nx;
   logic [AW-1:0]       rd_pos, key_pos, rd_addr, wr_addr;
   logic [CW-1:0]       j_m1;
   logic [EW-1:0]       wr_data;

   assign rd_val  = rd_ff[EW-1 -: VALUE_W];
   assign rd_cnt  = rd_ff[AW +: CW];
   assign rd_pos  = rd_ff[AW-1:0];
   assign key_cnt = key_ff[AW +: CW];
   assign key_pos = key_ff[AW-1:0];
   assign j_m1    = j_ff - 1'b1;

   assign eff_cnt       = (repeat_ff == '0) ? rd_cnt : repeat_ff;
   assign rem_cnt       = eff_cnt - 1'b1;
   assign read_entry_nx = read_entry_ff + 1'b1;

   always_comb begin
      case (cmd.rd_sel)
         RD_K:    rd_addr = k_ff[AW-1:0];
         RD_JM1:  rd_addr = j_m1[AW-1:0];
         RD_READ: rd_addr = read_entry_ff[AW-1:0];
         default: rd_addr = k_ff[AW-1:0];
      endcase
      case (cmd.wr_sel)
         WR_NEW: begin
            wr_addr = distinct_ff[AW-1:0];
            wr_data = {val_ff, CW'(1), items_ff[AW-1:0]};
         end
         WR_INC: begin
            wr_addr = k_ff[AW-1:0];
            wr_data = {rd_val, rd_cnt + 1'b1, rd_pos};
         end
         WR_KEY: begin
            wr_addr = j_ff[AW-1:0];
            wr_data = key_ff;
         end
         default: begin
            wr_addr = j_ff[AW-1:0];
            wr_data = rd_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff  <= opcode_type'(req_tuser);
         val_ff <= req_tdata;
      end
      if (cmd.key_load) begin
         key_ff <= rd_ff;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.res_code;
         res_value_ff  <= '0;
         res_last_ff   <= 1'b0;
      end else if (cmd.read_step) begin
         res_status_ff <= ST_VALUE;
         res_value_ff  <= rd_val;
         res_last_ff   <= (rem_cnt == '0) && (read_entry_nx >= distinct_ff);
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_last_ff   <= res_last_ff;
      end
      case (cmd.k_op)
         K_ZERO:  k_ff <= '0;
         K_ONE:   k_ff <= CW'(1);
         K_INC:   k_ff <= k_ff + 1'b1;
         default: k_ff <= k_ff;
      endcase
      if (cmd.j_load) begin
         j_ff <= k_ff;
      end else if (cmd.j_dec) begin
         j_ff <= j_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff      <= '0;
         distinct_ff   <= '0;
         reading_ff    <= 1'b0;
         read_entry_ff <= '0;
         repeat_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.clear) begin
            items_ff      <= '0;
            distinct_ff   <= '0;
            reading_ff    <= 1'b0;
            read_entry_ff <= '0;
            repeat_ff     <= '0;
         end else begin
            if (cmd.items_inc) begin
               items_ff <= items_ff + 1'b1;
            end
            if (cmd.distinct_inc) begin
               distinct_ff <= distinct_ff + 1'b1;
            end
            if (cmd.start_read) begin
               reading_ff    <= 1'b1;
               read_entry_ff <= '0;
               repeat_ff     <= '0;
            end else if (cmd.read_step) begin
               repeat_ff <= rem_cnt;
               if (rem_cnt == '0) begin
                  read_entry_ff <= read_entry_nx;
               end
            end
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.opcode     = op_ff;
      sts.reading    = reading_ff;
      sts.full       = items_ff >= CW'(MAX_ITEMS);
      sts.items_zero = items_ff == '0;
      sts.k_end      = k_ff >= distinct_ff;
      sts.match      = rd_val == val_ff;
      sts.j_zero     = j_ff == '0;
      sts.key_first  = (key_cnt > rd_cnt) || ((key_cnt == rd_cnt) && (key_pos < rd_pos));
      sts.past_end   = read_entry_ff >= distinct_ff;
      sts.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_distinct_le_items: assert property (@(posedge clock) disable iff (reset)
      distinct_ff <= items_ff) else $error("distinct count above item count");
   a_items_bound: assert property (@(posedge clock) disable iff (reset)
      items_ff <= CW'(MAX_ITEMS)) else $error("item count above capacity");
   a_reading_nonempty: assert property (@(posedge clock) disable iff (reset)
      reading_ff |-> (items_ff != '0) && (read_entry_ff <= distinct_ff))
      else $error("read pointer out of range");
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (items_ff == '0) && !reading_ff) else $error("clear left state");

endmodule

@@ hw/rtl/frequency_sort_engine_core.sv @@
// Frequency sort engine. Requests carry an opcode in req_tuser (add, read, clear) and a
// signed 32-bit value in req_tdata; every request yields exactly one response with a status
// in rsp_tuser, the sorted value in rsp_tdata and the final-value flag on rsp_tlast. All
// table work goes through one single-port entry memory with a registered read, one access
// per cycle. An add looks for its value by a linear search over the distinct values held.
// The first read sorts the table by insertion sort and then returns the first value; later
// reads return the next value of the sorted table. A clear empties the table.
// A new request is taken as soon as the engine is idle, even while a response still waits.
module frequency_sort_engine_core #(
   parameter int MAX_ITEMS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [frqsrt_pkg::REQ_DATA_W-1:0]  req_tdata,  // value
   input  logic [frqsrt_pkg::REQ_USER_W-1:0]  req_tuser,  // opcode
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [frqsrt_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // sorted_value
   output logic [frqsrt_pkg::RSP_USER_W-1:0]  rsp_tuser,  // status
   output logic                               rsp_tlast
);
   import frqsrt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type sts;

   frqsrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   frqsrt_dp #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule
